FILE: design/cfba_pkg.sv
// Shared types, codes and command/status bundles for the chunked block allocator.
// No dependencies; every other design file refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none
package cfba_pkg;

	localparam int MAX_CHUNKS = 16;
	localparam int MAX_BLOCKS = 255;
	localparam int REG_W      = $clog2(MAX_CHUNKS);
	localparam int POS_W      = REG_W + 1;
	localparam int BLK_W      = 8;
	localparam int ADDR_W     = REG_W + BLK_W;

	typedef logic [REG_W-1:0]  region_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [BLK_W-1:0]  blk_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [1:0]        status_t;

	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_OOM = 2'd1;
	localparam status_t ST_BAD = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef struct packed {
		logic    ld_in;
		logic    pos_zero;
		logic    pos_inc;
		logic    pos_dec;
		logic    pos_last;
		logic    sel_pos;
		logic    reg_zero;
		logic    reg_inc;
		logic    cnt_zero;
		logic    cnt_inc;
		logic    sweep_wr;
		logic    open_chunk;
		logic    take_rd;
		logic    take_upd;
		logic    free_upd;
		logic    drop_tail;
		logic    drop_last;
		logic    swap;
		logic    fc_sel_co;
		logic    st_ld;
		status_t st_code;
		logic    st_alloc;
		logic    out_ld;
	} cmd_t;

	typedef struct packed {
		logic cache_hit;
		logic pos_end;
		logic fc_co_nz;
		logic co_match;
		logic live_full;
		logic rl_reg;
		logic reg_last;
		logic sweep_last;
		logic free_bad;
		logic free_fills;
		logic pos_is_last;
		logic live_gt1;
		logic fc_co_full;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: design/cfba_if.sv
// Request and response channel interfaces for the allocator.
// Payload types come from cfba_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cfba_req_if;
	logic                  valid;
	logic                  ready;
	logic                  func;
	cfba_pkg::region_t     free_region;
	cfba_pkg::blk_t        free_block;

	modport source (output valid, output func, output free_region, output free_block,
		input ready);
	modport sink (input valid, input func, input free_region, input free_block,
		output ready);
endinterface

interface cfba_rsp_if;
	logic                  valid;
	logic                  ready;
	cfba_pkg::status_t     status;
	cfba_pkg::region_t     region;
	cfba_pkg::blk_t        block;
	cfba_pkg::pos_t        chunks_in_use;

	modport source (output valid, output status, output region, output block,
		output chunks_in_use, input ready);
	modport sink (input valid, input status, input region, input block,
		input chunks_in_use, output ready);
endinterface
`default_nettype wire

FILE: design/chunked_fixed_block_allocator_top.sv
// Top level of the chunked fixed-size block allocator.
// Instantiates cfba_ctrl and cfba_dp; channel types from cfba_if.sv, cfba_pkg.
//
//  channel  | dir | payload                                   | handshake
//  req      | in  | func, free_region, free_block              | valid/ready
//  rsp      | out | status, region, block, chunks_in_use       | valid/ready
//  cfg      | in  | blocks_per_chunk (cfg_wdata)               | cfg_we
//
// Cached allocate checks the cached chunk, then takes its head block; on a miss
// the chunks are scanned in list order. Opening a chunk searches for a free
// region, then threads its links, one link write per cycle on the single link
// memory port. Free checks that the region is live, then scans chunk positions
// for the match. One request at a time.
// Reset clears all tables; link memory contents are not cleared.
// A stalled response is held in the output register; the next request is taken
// once the previous response has been loaded there.
`timescale 1ns / 1ps
`default_nettype none
module chunked_fixed_block_allocator_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic [7:0] cfg_wdata,
	cfba_req_if.sink    req,
	cfba_rsp_if.source  rsp
);

	cfba_pkg::cmd_t cmd;
	cfba_pkg::sts_t sts;

	cfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cfba_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_func   (req.func),
		.req_region (req.free_region),
		.req_block  (req.free_block),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_region (rsp.region),
		.out_block  (rsp.block),
		.out_chunks (rsp.chunks_in_use)
	);

endmodule
`default_nettype wire

FILE: design/cfba_ctrl.sv
// Sequencer for the allocator: walks one request through its scan, open,
// take and release steps. Drives cfba_dp through cfba_pkg::cmd_t / sts_t.
`timescale 1ns / 1ps
`default_nettype none
module cfba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_func,
	output logic               req_ready,
	input  wire cfba_pkg::sts_t sts,
	output cfba_pkg::cmd_t     cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_A_CHK   = 4'd1;
	localparam logic [3:0] S_A_SCAN  = 4'd2;
	localparam logic [3:0] S_A_NEW   = 4'd3;
	localparam logic [3:0] S_A_FIND  = 4'd4;
	localparam logic [3:0] S_A_SWEEP = 4'd5;
	localparam logic [3:0] S_A_OPEN  = 4'd6;
	localparam logic [3:0] S_A_TAKE  = 4'd7;
	localparam logic [3:0] S_A_TAKE2 = 4'd8;
	localparam logic [3:0] S_F_CHK   = 4'd9;
	localparam logic [3:0] S_F_SCAN  = 4'd10;
	localparam logic [3:0] S_F_EMPTY = 4'd11;
	localparam logic [3:0] S_F_PREV  = 4'd12;
	localparam logic [3:0] S_F_LAST  = 4'd13;
	localparam logic [3:0] S_RESP    = 4'd14;

	logic [3:0] state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = (req_func == cfba_pkg::FUNC_FREE) ? S_F_CHK : S_A_CHK;
				end
			end
			S_A_CHK: begin
				cmd.fc_sel_co = 1'b1;
				if (sts.cache_hit) begin
					cmd.sel_pos = 1'b1;
					state_d     = S_A_TAKE;
				end else begin
					cmd.pos_zero = 1'b1;
					state_d      = S_A_SCAN;
				end
			end
			S_A_SCAN: begin
				cmd.fc_sel_co = 1'b1;
				if (sts.pos_end) begin
					state_d = S_A_NEW;
				end else if (sts.fc_co_nz) begin
					cmd.sel_pos = 1'b1;
					state_d     = S_A_TAKE;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			S_A_NEW: begin
				if (sts.live_full) begin
					cmd.st_ld   = 1'b1;
					cmd.st_code = cfba_pkg::ST_OOM;
					state_d     = S_RESP;
				end else begin
					cmd.reg_zero = 1'b1;
					state_d      = S_A_FIND;
				end
			end
			S_A_FIND: begin
				if (!sts.rl_reg) begin
					cmd.cnt_zero = 1'b1;
					state_d      = S_A_SWEEP;
				end else if (sts.reg_last) begin
					cmd.st_ld   = 1'b1;
					cmd.st_code = cfba_pkg::ST_OOM;
					state_d     = S_RESP;
				end else begin
					cmd.reg_inc = 1'b1;
				end
			end
			S_A_SWEEP: begin
				// thread the fresh chunk's links one block per cycle
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_A_OPEN;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_A_OPEN: begin
				cmd.open_chunk = 1'b1;
				state_d        = S_A_TAKE;
			end
			S_A_TAKE: begin
				cmd.take_rd = 1'b1;
				state_d     = S_A_TAKE2;
			end
			S_A_TAKE2: begin
				cmd.take_upd = 1'b1;
				cmd.st_ld    = 1'b1;
				cmd.st_code  = cfba_pkg::ST_OK;
				cmd.st_alloc = 1'b1;
				state_d      = S_RESP;
			end
			S_F_CHK: begin
				if (!sts.rl_reg) begin
					cmd.st_ld   = 1'b1;
					cmd.st_code = cfba_pkg::ST_BAD;
					state_d     = S_RESP;
				end else begin
					state_d = S_F_SCAN;
				end
			end
			S_F_SCAN: begin
				if (sts.pos_end) begin
					cmd.st_ld   = 1'b1;
					cmd.st_code = cfba_pkg::ST_BAD;
					state_d     = S_RESP;
				end else if (sts.co_match) begin
					cmd.st_ld = 1'b1;
					if (sts.free_bad) begin
						cmd.st_code = cfba_pkg::ST_BAD;
						state_d     = S_RESP;
					end else begin
						cmd.free_upd = 1'b1;
						cmd.st_code  = cfba_pkg::ST_OK;
						state_d      = sts.free_fills ? S_F_EMPTY : S_RESP;
					end
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			S_F_EMPTY: begin
				if (sts.pos_is_last) begin
					if (sts.live_gt1) begin
						cmd.pos_dec = 1'b1;
						state_d     = S_F_PREV;
					end else begin
						state_d = S_RESP;
					end
				end else begin
					cmd.pos_last = 1'b1;
					state_d      = S_F_LAST;
				end
			end
			S_F_PREV: begin
				cmd.fc_sel_co = 1'b1;
				if (sts.fc_co_full) begin
					cmd.drop_tail = 1'b1;
				end
				state_d = S_RESP;
			end
			S_F_LAST: begin
				cmd.fc_sel_co = 1'b1;
				if (sts.fc_co_full) begin
					cmd.drop_last = 1'b1;
				end else begin
					cmd.swap = 1'b1;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/cfba_dp.sv
// Datapath for the allocator: chunk tables, link memory, cursors and the
// output register. Uses cfba_pkg; commanded by cfba_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module cfba_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_wdata,
	input  wire logic               req_func,
	input  wire cfba_pkg::region_t  req_region,
	input  wire cfba_pkg::blk_t     req_block,
	input  wire cfba_pkg::cmd_t     cmd,
	output cfba_pkg::sts_t          sts,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output cfba_pkg::status_t       out_status,
	output cfba_pkg::region_t       out_region,
	output cfba_pkg::blk_t          out_block,
	output cfba_pkg::pos_t          out_chunks
);

	localparam int NC = cfba_pkg::MAX_CHUNKS;

	cfba_pkg::blk_t    ff_q [NC];
	cfba_pkg::blk_t    fc_q [NC];
	cfba_pkg::region_t co_q [NC];
	logic [NC-1:0]     rl_q;
	cfba_pkg::pos_t    live_q;
	cfba_pkg::region_t alloc_pos_q;
	logic              alloc_valid_q;
	cfba_pkg::region_t dealloc_pos_q;
	cfba_pkg::pos_t    pos_q;
	cfba_pkg::region_t reg_q;
	cfba_pkg::blk_t    blk_q;
	cfba_pkg::blk_t    cnt_q;
	logic [7:0]        bpc_q;
	cfba_pkg::status_t stat_q;
	logic              is_alloc_q;

	cfba_pkg::blk_t    link_mem [2**cfba_pkg::ADDR_W];
	cfba_pkg::blk_t    rdata_q;

	cfba_pkg::blk_t    n_eff;
	cfba_pkg::region_t co_rd;
	cfba_pkg::region_t fc_idx;
	cfba_pkg::blk_t    fc_rd;
	cfba_pkg::blk_t    ff_rd;
	logic              mem_we;
	cfba_pkg::addr_t   mem_waddr;
	cfba_pkg::blk_t    mem_wdata;

	assign n_eff  = (bpc_q == 8'd0) ? 8'd1 : bpc_q;
	assign co_rd  = co_q[pos_q[cfba_pkg::REG_W-1:0]];
	assign fc_idx = cmd.fc_sel_co ? co_rd : reg_q;
	assign fc_rd  = fc_q[fc_idx];
	assign ff_rd  = ff_q[reg_q];

	always_comb begin
		sts.cache_hit   = alloc_valid_q && (pos_q < live_q) && (fc_rd != 8'd0);
		sts.pos_end     = (pos_q == live_q);
		sts.fc_co_nz    = (fc_rd != 8'd0);
		sts.co_match    = (co_rd == reg_q);
		sts.live_full   = (live_q == cfba_pkg::POS_W'(NC));
		sts.rl_reg      = rl_q[reg_q];
		sts.reg_last    = (reg_q == cfba_pkg::REG_W'(NC - 1));
		sts.sweep_last  = (cnt_q == n_eff - 8'd1);
		sts.free_bad    = (blk_q >= n_eff) || (fc_rd >= n_eff);
		sts.free_fills  = (({1'b0, fc_rd} + 9'd1) == {1'b0, n_eff});
		sts.pos_is_last = (pos_q == live_q - 5'd1);
		sts.live_gt1    = (live_q > 5'd1);
		sts.fc_co_full  = (fc_rd == n_eff);
		sts.out_free    = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpc_q <= 8'd255;
		end else if (cfg_we) begin
			bpc_q <= cfg_wdata;
		end
	end

	// cursors and request fields
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			reg_q <= req_region;
			blk_q <= req_block;
			pos_q <= (req_func == cfba_pkg::FUNC_FREE) ? '0 : {1'b0, alloc_pos_q};
		end else if (cmd.pos_zero) begin
			pos_q <= '0;
		end else if (cmd.pos_inc) begin
			pos_q <= pos_q + 5'd1;
		end else if (cmd.pos_dec) begin
			pos_q <= pos_q - 5'd1;
		end else if (cmd.pos_last) begin
			pos_q <= live_q - 5'd1;
		end
		if (cmd.sel_pos) begin
			reg_q <= co_rd;
		end else if (cmd.reg_zero) begin
			reg_q <= '0;
		end else if (cmd.reg_inc) begin
			reg_q <= reg_q + 4'd1;
		end
		if (cmd.take_rd) begin
			blk_q <= ff_rd;
		end
		if (cmd.cnt_zero) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 8'd1;
		end
		if (cmd.st_ld) begin
			stat_q     <= cmd.st_code;
			is_alloc_q <= cmd.st_alloc;
		end
	end

	// chunk tables and allocation cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				ff_q[i] <= '0;
				fc_q[i] <= '0;
				co_q[i] <= '0;
			end
			rl_q          <= '0;
			live_q        <= '0;
			alloc_pos_q   <= '0;
			alloc_valid_q <= 1'b0;
			dealloc_pos_q <= '0;
		end else begin
			if (cmd.sel_pos) begin
				alloc_pos_q   <= pos_q[cfba_pkg::REG_W-1:0];
				alloc_valid_q <= 1'b1;
			end
			if (cmd.open_chunk) begin
				ff_q[reg_q]                            <= '0;
				fc_q[reg_q]                            <= n_eff;
				rl_q[reg_q]                            <= 1'b1;
				co_q[live_q[cfba_pkg::REG_W-1:0]]      <= reg_q;
				alloc_pos_q                            <= live_q[cfba_pkg::REG_W-1:0];
				alloc_valid_q                          <= 1'b1;
				live_q                                 <= live_q + 5'd1;
				dealloc_pos_q                          <= '0;
			end
			if (cmd.take_upd) begin
				ff_q[reg_q] <= rdata_q;
				fc_q[reg_q] <= fc_q[reg_q] - 8'd1;
			end
			if (cmd.free_upd) begin
				ff_q[reg_q]   <= blk_q;
				fc_q[reg_q]   <= fc_rd + 8'd1;
				dealloc_pos_q <= pos_q[cfba_pkg::REG_W-1:0];
			end
			if (cmd.drop_tail) begin
				// freed chunk is the tail and sits behind another empty chunk
				live_q        <= live_q - 5'd1;
				rl_q[reg_q]   <= 1'b0;
				alloc_pos_q   <= '0;
				dealloc_pos_q <= '0;
				alloc_valid_q <= 1'b1;
			end
			if (cmd.drop_last) begin
				live_q        <= live_q - 5'd1;
				rl_q[co_rd]   <= 1'b0;
				alloc_pos_q   <= dealloc_pos_q;
				alloc_valid_q <= 1'b1;
			end
			if (cmd.swap) begin
				// move the empty chunk to the tail
				co_q[dealloc_pos_q]                 <= co_rd;
				co_q[pos_q[cfba_pkg::REG_W-1:0]]    <= reg_q;
				alloc_pos_q                         <= pos_q[cfba_pkg::REG_W-1:0];
				alloc_valid_q                       <= 1'b1;
			end
		end
	end

	// link memory: one write port, one registered read port
	always_comb begin
		mem_we    = cmd.sweep_wr || cmd.free_upd;
		mem_waddr = cmd.sweep_wr ? {reg_q, cnt_q} : {reg_q, blk_q};
		mem_wdata = cmd.sweep_wr ? (cnt_q + 8'd1) : ff_rd;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.take_rd) begin
			rdata_q <= link_mem[{reg_q, ff_rd}];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_status <= stat_q;
			out_region <= (is_alloc_q && stat_q == cfba_pkg::ST_OK) ? reg_q : '0;
			out_block  <= (is_alloc_q && stat_q == cfba_pkg::ST_OK) ? blk_q : '0;
			out_chunks <= live_q;
		end
	end

endmodule
`default_nettype wire

FILE: tb/cfba_alloc_checker.sv
// Checker for the chunked block allocator: watches config, request and response
// traffic, predicts every response and compares it. Depends on cfba_pkg, cfba_if.sv.
`timescale 1ns / 1ps
module cfba_alloc_checker (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic [7:0] cfg_wdata,
	cfba_req_if    req,
	cfba_rsp_if    rsp,
	output int     errors,
	output int     n_left
);

	typedef struct {
		cfba_pkg::status_t status;
		cfba_pkg::region_t region;
		cfba_pkg::blk_t    block;
		cfba_pkg::pos_t    chunks_in_use;
	} alloc_rsp_t;

	alloc_rsp_t want_rsp[$];

	cfba_pkg::blk_t    link[cfba_pkg::MAX_CHUNKS][256];
	cfba_pkg::blk_t    head[cfba_pkg::MAX_CHUNKS];
	cfba_pkg::blk_t    cnt[cfba_pkg::MAX_CHUNKS];
	cfba_pkg::region_t order[cfba_pkg::MAX_CHUNKS];
	logic    live[cfba_pkg::MAX_CHUNKS];
	int      nlive;
	int      cpos;
	logic    cached;
	int      dpos;
	logic [7:0] bpc;

	task automatic report(input string what, input int got, input int exp);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	function automatic void drop_tail();
		nlive--;
		live[order[nlive]] = 1'b0;
	endfunction

	function automatic alloc_rsp_t alloc_predict(logic f, cfba_pkg::region_t fr,
		cfba_pkg::blk_t fb);
		alloc_rsp_t o;
		int pos, r, b, n, last;
		cfba_pkg::region_t t;
		o = '{cfba_pkg::ST_OK, '0, '0, '0};
		n = (bpc == 0) ? 1 : bpc;
		if (f == cfba_pkg::FUNC_ALLOC) begin
			if (!(cached && cpos < nlive && cnt[order[cpos]] > 0)) begin
				pos = nlive;
				for (int i = nlive - 1; i >= 0; i--)
					if (cnt[order[i]] > 0) pos = i;
				if (pos == nlive) begin
					r = cfba_pkg::MAX_CHUNKS;
					for (int i = cfba_pkg::MAX_CHUNKS - 1; i >= 0; i--)
						if (!live[i]) r = i;
					if (nlive >= cfba_pkg::MAX_CHUNKS || r == cfba_pkg::MAX_CHUNKS) begin
						o.status = cfba_pkg::ST_OOM;
						o.chunks_in_use = cfba_pkg::pos_t'(nlive);
						return o;
					end
					// thread a fresh free list through the new chunk
					for (int i = 0; i < n; i++) link[r][i] = cfba_pkg::blk_t'(i + 1);
					head[r] = '0;
					cnt[r] = cfba_pkg::blk_t'(n);
					live[r] = 1'b1;
					order[nlive] = cfba_pkg::region_t'(r);
					pos = nlive;
					nlive++;
					dpos = 0;
				end
				cpos = pos;
				cached = 1'b1;
			end
			r = order[cpos];
			b = head[r];
			head[r] = link[r][b];
			cnt[r]--;
			o.region = cfba_pkg::region_t'(r);
			o.block = cfba_pkg::blk_t'(b);
		end else begin
			pos = nlive;
			for (int i = nlive - 1; i >= 0; i--)
				if (order[i] == fr) pos = i;
			if (!live[fr] || pos == nlive || fb >= n || cnt[fr] >= n) begin
				o.status = cfba_pkg::ST_BAD;
				o.chunks_in_use = cfba_pkg::pos_t'(nlive);
				return o;
			end
			dpos = pos;
			link[fr][fb] = head[fr];
			head[fr] = fb;
			cnt[fr]++;
			if (cnt[fr] == n) begin
				last = nlive - 1;
				if (pos == last) begin
					if (nlive > 1 && cnt[order[pos-1]] == n) begin
						drop_tail();
						cpos = 0;
						dpos = 0;
						cached = 1'b1;
					end
				end else if (cnt[order[last]] == n) begin
					drop_tail();
					cpos = dpos;
					cached = 1'b1;
				end else begin
					// move the empty chunk to the tail
					t = order[pos];
					order[pos] = order[last];
					order[last] = t;
					cpos = last;
					cached = 1'b1;
				end
			end
		end
		o.chunks_in_use = cfba_pkg::pos_t'(nlive);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < cfba_pkg::MAX_CHUNKS; i++) begin
				head[i] = '0;
				cnt[i] = '0;
				order[i] = '0;
				live[i] = 1'b0;
			end
			nlive = 0;
			cpos = 0;
			cached = 1'b0;
			dpos = 0;
			bpc = 8'd255;
			errors = 0;
			want_rsp.delete();
		end else begin
			if (cfg_we) bpc = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				if (want_rsp.size() == 0) begin
					report("unexpected response", rsp.status, -1);
				end else begin
					e = want_rsp.pop_front();
					if (rsp.status !== e.status) report("status", rsp.status, e.status);
					if (rsp.region !== e.region) report("region", rsp.region, e.region);
					if (rsp.block !== e.block) report("block", rsp.block, e.block);
					if (rsp.chunks_in_use !== e.chunks_in_use)
						report("chunks_in_use", rsp.chunks_in_use, e.chunks_in_use);
				end
			end
			if (req.valid && req.ready)
				want_rsp.insert(want_rsp.size(),
					alloc_predict(req.func, req.free_region, req.free_block));
		end
		n_left = want_rsp.size();
	end
endmodule

FILE: tb/chunked_fixed_block_allocator_top_test.sv
// Stimulus and verdict for chunked_fixed_block_allocator_top.
// Depends on cfba_pkg, cfba_if.sv and tb/cfba_alloc_checker.sv.
`timescale 1ns / 1ps
module chunked_fixed_block_allocator_top_test;

	localparam int LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic [7:0] cur_bpc = 8'd255;
	logic hold_rsp = 1'b0;
	logic calm = 1'b0;
	logic collect = 1'b0;
	int errors, n_left;
	int cycles = 0;
	int n_sent = 0, n_got = 0, n_oom = 0, n_bad = 0, n_ok_alloc = 0;
	logic sent_func[$];
	logic [11:0] held[$];

	cfba_req_if req();
	cfba_rsp_if rsp();

	chunked_fixed_block_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp)
	);

	cfba_alloc_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp), .errors(errors), .n_left(n_left)
	);

	always #6 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.func = cfba_pkg::FUNC_ALLOC;
		req.free_region = '0;
		req.free_block = '0;
		rsp.ready = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 70) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// track allocated handles and response statistics
	always @(posedge clk) begin
		logic f;
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("chunked_fixed_block_allocator_top_test failed");
			$finish;
		end
		if (req.valid && req.ready) begin
			sent_func.insert(sent_func.size(), req.func);
			n_sent++;
		end
		if (rsp.valid && rsp.ready) begin
			n_got++;
			f = sent_func.pop_front();
			if (rsp.status == cfba_pkg::ST_OOM) n_oom++;
			if (rsp.status == cfba_pkg::ST_BAD) n_bad++;
			if (f == cfba_pkg::FUNC_ALLOC && rsp.status == cfba_pkg::ST_OK) begin
				n_ok_alloc++;
				if (collect) held.insert(held.size(), {rsp.region, rsp.block});
			end
		end
	end

	// response side: random stalls, plus one long hold when asked
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				for (k = 0; k < 400; k++) @(negedge clk);
				hold_rsp = 1'b0;
				rsp.ready <= 1'b1;
			end else begin
				k = pick_gap();
				if (k > 0) begin
					rsp.ready <= 1'b0;
					repeat (k - 1) @(negedge clk);
				end else begin
					rsp.ready <= 1'b1;
				end
			end
		end
	end

	task automatic send_req(input logic f, input cfba_pkg::region_t r,
		input cfba_pkg::blk_t b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.func <= f;
		req.free_region <= r;
		req.free_block <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (n_got != n_sent) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_bpc(input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		cur_bpc = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_req(input int alloc_pct);
		int r, idx, n;
		logic [11:0] h;
		n = (cur_bpc == 0) ? 1 : cur_bpc;
		r = $urandom_range(99);
		if (r < alloc_pct || held.size() == 0) begin
			send_req(cfba_pkg::FUNC_ALLOC, cfba_pkg::region_t'($urandom),
				cfba_pkg::blk_t'($urandom));
		end else if (r < alloc_pct + 8) begin
			// out-of-range block, any region
			send_req(cfba_pkg::FUNC_FREE, cfba_pkg::region_t'($urandom_range(15)),
				cfba_pkg::blk_t'($urandom_range(255, n)));
		end else begin
			idx = $urandom_range(held.size() - 1);
			h = held[idx];
			held.delete(idx);
			send_req(cfba_pkg::FUNC_FREE, h[11:8], h[7:0]);
		end
	endtask

	initial begin
		logic [7:0] bpc_list[8];
		int pct_list[8];
		bpc_list = '{8'd255, 8'd8, 8'd0, 8'd3, 8'd128, 8'd1, 8'd37, 8'd2};
		pct_list = '{60, 55, 70, 50, 65, 45, 60, 50};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// directed: one block per chunk, fill all chunks, then free corner cases
		write_bpc(8'd1);
		send_req(cfba_pkg::FUNC_FREE, 4'd3, 8'd0);
		repeat (17) send_req(cfba_pkg::FUNC_ALLOC, 4'd0, 8'd0);
		send_req(cfba_pkg::FUNC_FREE, 4'd15, 8'd0);
		send_req(cfba_pkg::FUNC_FREE, 4'd0, 8'd0);
		send_req(cfba_pkg::FUNC_FREE, 4'd2, 8'd1);
		send_req(cfba_pkg::FUNC_FREE, 4'd0, 8'd0);
		send_req(cfba_pkg::FUNC_FREE, 4'd15, 8'd0);
		drain();
		for (int i = 1; i < 15; i++) held.insert(held.size(), {cfba_pkg::region_t'(i), 8'd0});
		collect = 1'b1;
		send_req(cfba_pkg::FUNC_ALLOC, 4'd0, 8'd0);
		drain();

		for (int p = 0; p < 8; p++) begin
			write_bpc(bpc_list[p]);
			calm = (p == 3);
			for (int i = 0; i < 128; i++) begin
				if (p == 1 && i == 40) hold_rsp = 1'b1;
				random_req(pct_list[p]);
			end
			drain();
		end
		calm = 1'b0;
		repeat (30) @(posedge clk);

		$display("requests %0d, responses %0d: %0d allocations, %0d out of memory, %0d bad frees",
			n_sent, n_got, n_ok_alloc, n_oom, n_bad);
		$display("block counts swept 0..255, %0d blocks still held", held.size());
		if (errors == 0 && n_left == 0 && n_got == n_sent) begin
			$display("chunked_fixed_block_allocator_top_test passed");
		end else begin
			$display("chunked_fixed_block_allocator_top_test failed");
		end
		$finish;
	end
endmodule

FILE: files.f
design/cfba_pkg.sv
design/cfba_if.sv
design/cfba_ctrl.sv
design/cfba_dp.sv
design/chunked_fixed_block_allocator_top.sv
tb/cfba_alloc_checker.sv
tb/chunked_fixed_block_allocator_top_test.sv
